// File: rtl/core/lkv_pkg.sv
package lkv_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam int CAP_BITS = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic valid;
        logic put;
    } req_ctrl_t;

endpackage

// File: rtl/core/lkv_in_stage.sv
module lkv_in_stage
    import lkv_pkg::*;
#(
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         cmd,
    input  logic [KEY_BITS-1:0]          key,
    input  logic signed [VALUE_BITS-1:0] value,
    output req_ctrl_t                    req_ctrl,
    output logic [KEY_BITS-1:0]          req_key,
    output logic [VALUE_BITS-1:0]        req_value
);

    req_ctrl_t               ctrl_reg;
    req_ctrl_t               ctrl_next;
    logic [KEY_BITS-1:0]     key_reg;
    logic [VALUE_BITS-1:0]   value_reg;

    always_comb
    begin
        ctrl_next.valid = accept;
        ctrl_next.put   = (cmd == CMD_PUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    // payload only
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg   <= key;
            value_reg <= value;
        end
    end

    assign req_ctrl  = ctrl_reg;
    assign req_key   = key_reg;
    assign req_value = value_reg;

endmodule

// File: rtl/core/lkv_store.sv
module lkv_store
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CAP_BITS-1:0]   capacity,
    input  req_ctrl_t             req_ctrl,
    input  logic [KEY_BITS-1:0]   req_key,
    input  logic [VALUE_BITS-1:0] req_value,
    output logic                  done,
    output logic                  hit,
    output logic [VALUE_BITS-1:0] read_value
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int CW = (OW > CAP_BITS) ? OW : CAP_BITS;

    logic [ENTRIES-1:0]    valid_reg;
    logic [ENTRIES-1:0]    valid_next;
    logic [IW-1:0]         age_reg  [ENTRIES];
    logic [IW-1:0]         age_next [ENTRIES];
    logic [KEY_BITS-1:0]   keys_mem [ENTRIES];
    logic [VALUE_BITS-1:0] vals_mem [ENTRIES];

    logic [ENTRIES-1:0]    match;
    logic [ENTRIES-1:0]    keep;
    logic                  hit_any;
    logic [IW-1:0]         hit_age;
    logic [IW-1:0]         hit_idx;
    logic [IW-1:0]         free_idx;
    logic [IW-1:0]         wr_idx;
    logic [VALUE_BITS-1:0] hit_val;
    logic [CW-1:0]         eff_cap;
    logic                  wr_en;

    logic                  done_reg;
    logic                  hit_reg;
    logic [VALUE_BITS-1:0] rd_reg;

    always_comb
    begin
        eff_cap = CW'(capacity);
        if (capacity == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (CW'(capacity) > CW'(ENTRIES))
        begin
            eff_cap = CW'(ENTRIES);
        end
    end

    // tag compare and eviction survivors
    always_comb
    begin
        hit_age = '0;
        hit_idx = '0;
        hit_val = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (keys_mem[i] == req_key);
            keep[i]  = valid_reg[i] && ((CW'(age_reg[i]) + CW'(1)) < eff_cap);
            if (match[i])
            begin
                hit_age = hit_age | age_reg[i];
                hit_idx = hit_idx | IW'(i);
                hit_val = hit_val | vals_mem[i];
            end
        end
        hit_any = |match;
    end

    // lowest free slot after eviction
    always_comb
    begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!keep[i])
            begin
                free_idx = IW'(i);
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            age_next[i] = age_reg[i];
        end
        if (req_ctrl.valid && hit_any)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (match[i])
                begin
                    age_next[i] = '0;
                end
                else if (valid_reg[i] && (age_reg[i] < hit_age))
                begin
                    age_next[i] = IW'(age_reg[i] + 1'b1);
                end
            end
        end
        else if (req_ctrl.valid && req_ctrl.put)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_next[i] = keep[i];
                age_next[i]   = keep[i] ? IW'(age_reg[i] + 1'b1) : '0;
            end
            valid_next[free_idx] = 1'b1;
            age_next[free_idx]   = '0;
        end
    end

    assign wr_en  = req_ctrl.valid && req_ctrl.put;
    assign wr_idx = hit_any ? hit_idx : free_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= age_next[i];
            end
            done_reg <= req_ctrl.valid && !req_ctrl.put;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            keys_mem[wr_idx] <= req_key;
            vals_mem[wr_idx] <= req_value;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_any;
        rd_reg  <= hit_val;
    end

    assign done       = done_reg;
    assign hit        = hit_reg;
    assign read_value = rd_reg;

    a_unique_keys: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("key present in more than one entry");

    a_put_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (req_ctrl.valid && req_ctrl.put) |=> (valid_reg != '0))
        else $error("store empty after put");

    a_done_for_get: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(req_ctrl.valid && !req_ctrl.put))
        else $error("result without a get transaction");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (read_value == '0))
        else $error("miss result carries a value");

endmodule

// File: rtl/core/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement. One get or put
// transaction is taken in every clock cycle (busy stays low); each get returns its result
// on done via the input register and the store's done register; a put returns nothing.
// The receiver cannot stall: done, hit and read_value are valid for one cycle only, so
// capture them then. The single lookup/update pass over the register store, between the
// two registers, also writes the store so the next transaction sees it. The user writes
// the capacity register (0 acts as 1, above ENTRIES acts as ENTRIES) via the cfg channel
// only with no transaction in flight (unenforced); lowering it evicts on next put miss.
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         cmd,
    input  logic [KEY_BITS-1:0]          key,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CAP_BITS-1:0]          cfg_data,
    output logic                         done,
    output logic                         hit,
    output logic signed [VALUE_BITS-1:0] read_value
);

    logic [CAP_BITS-1:0]   capacity_reg;
    req_ctrl_t             req_ctrl;
    logic [KEY_BITS-1:0]   req_key;
    logic [VALUE_BITS-1:0] req_value;
    logic [VALUE_BITS-1:0] rd_value;
    logic                  accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            capacity_reg <= cfg_data;
        end
    end

    lkv_in_stage #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (cmd),
        .key       (key),
        .value     (value),
        .req_ctrl  (req_ctrl),
        .req_key   (req_key),
        .req_value (req_value)
    );

    lkv_store #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .capacity   (capacity_reg),
        .req_ctrl   (req_ctrl),
        .req_key    (req_key),
        .req_value  (req_value),
        .done       (done),
        .hit        (hit),
        .read_value (rd_value)
    );

    assign read_value = rd_value;

endmodule
